>>> rtl/sfb_pkg.sv
// Shared types and constants for the sample frame builder.
`timescale 1ns / 1ps
package sfb_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned KIND_BITS   = 3;
  localparam int unsigned SPF_BITS    = 9;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [BYTE_BITS-1:0]   byte_t;
  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [SPF_BITS-1:0]    spf_t;

  // byte_kind codes
  localparam kind_t KIND_PREAMBLE = 3'd0;
  localparam kind_t KIND_START    = 3'd1;
  localparam kind_t KIND_SAMPLE   = 3'd2;
  localparam kind_t KIND_CHECKSUM = 3'd3;
  localparam kind_t KIND_END      = 3'd4;

  // register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_SPF      = 2'd0;
  localparam logic [1:0] REG_PREAMBLE = 2'd1;
  localparam logic [1:0] REG_START    = 2'd2;
  localparam logic [1:0] REG_END      = 2'd3;

  localparam spf_t  SPF_RESET      = 9'd128;
  localparam byte_t PREAMBLE_RESET = 8'hAA;
  localparam byte_t START_RESET    = 8'h53;
  localparam byte_t END_RESET      = 8'h45;

  typedef struct packed {
    spf_t  samples_per_frame;
    byte_t preamble_byte;
    byte_t start_byte;
    byte_t end_byte;
  } cfg_t;

  // what one accepted sample turns into
  typedef struct packed {
    byte_t data;
    byte_t checksum;
    logic  first;
    logic  last;
  } item_t;

endpackage

>>> rtl/sfb_in_if.sv
// Sample input channel: valid/ready with one converter reading.
`timescale 1ns / 1ps
interface sfb_in_if;
  import sfb_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/sfb_out_if.sv
// Byte output channel: valid/ready with byte, kind and end-of-run flag.
`timescale 1ns / 1ps
interface sfb_out_if;
  import sfb_pkg::*;

  logic  valid;
  logic  ready;
  byte_t tx_byte;
  kind_t byte_kind;
  logic  last_of_run;

  modport source (output valid, output tx_byte, output byte_kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input tx_byte, input byte_kind, input last_of_run,
                  output ready);
endinterface

>>> rtl/sfb_cfg_regs.sv
// APB register block holding frame length and flag bytes.
`timescale 1ns / 1ps
module sfb_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfb_pkg::APB_AW-1:0]  paddr,
  input  logic [sfb_pkg::APB_DW-1:0]  pwdata,
  output logic [sfb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output sfb_pkg::cfg_t               cfg_o
);
  import sfb_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SPF:      cfg_d.samples_per_frame = pwdata[SPF_BITS-1:0];
        REG_PREAMBLE: cfg_d.preamble_byte     = pwdata[BYTE_BITS-1:0];
        REG_START:    cfg_d.start_byte        = pwdata[BYTE_BITS-1:0];
        REG_END:      cfg_d.end_byte          = pwdata[BYTE_BITS-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_frame <= SPF_RESET;
      cfg_q.preamble_byte     <= PREAMBLE_RESET;
      cfg_q.start_byte        <= START_RESET;
      cfg_q.end_byte          <= END_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SPF:      prdata[SPF_BITS-1:0]  = cfg_q.samples_per_frame;
      REG_PREAMBLE: prdata[BYTE_BITS-1:0] = cfg_q.preamble_byte;
      REG_START:    prdata[BYTE_BITS-1:0] = cfg_q.start_byte;
      REG_END:      prdata[BYTE_BITS-1:0] = cfg_q.end_byte;
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sfb_frame_ctl.sv
// Frame position and running checksum; classifies each accepted sample.
`timescale 1ns / 1ps
module sfb_frame_ctl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  sfb_pkg::sample_t    sample_i,
  input  sfb_pkg::spf_t       spf_i,
  output sfb_pkg::item_t      item_o
);
  import sfb_pkg::*;

  byte_t            pos_q, pos_d;
  byte_t            sum_q, sum_d;
  byte_t            data;
  byte_t            sum_next;
  spf_t             frame_len;
  logic [SPF_BITS-1:0] pos_inc;
  logic             last;

  // zero acts as one, anything above 256 acts as 256
  always_comb begin
    priority if (spf_i == '0) begin
      frame_len = 9'd1;
    end else if (spf_i[8] && (spf_i[7:0] != '0)) begin
      frame_len = 9'd256;
    end else begin
      frame_len = spf_i;
    end
  end

  assign data     = sample_i[SAMPLE_BITS-1 -: BYTE_BITS];
  assign sum_next = sum_q + data;
  assign pos_inc  = {1'b0, pos_q} + 9'd1;
  assign last     = (pos_inc >= frame_len);

  assign item_o.data     = data;
  assign item_o.checksum = sum_next;
  assign item_o.first    = (pos_q == '0);
  assign item_o.last     = last;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept_i) begin
      if (last) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_inc[BYTE_BITS-1:0];
        sum_d = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

endmodule

>>> rtl/sample_frame_builder.sv
// Top level: builds preamble/start/sample/checksum/end byte frames from samples.
//
//  channel   dir  signals                                  transfer
//  in_ch_i   in   valid ready sample[9:0]               one sample
//  out_ch_o  out  valid ready tx_byte byte_kind last_of_run  one frame byte
//  apb       in   psel penable pwrite paddr pwdata prdata pready   register write/read
//
// Each sample gives 1 to 6 bytes, one byte per cycle through the output register while
// the output is not stalled: 1 mid-frame, up to 6 for a one-sample frame, since the
// output channel has a single byte lane.
// The next sample is taken in the cycle its predecessor's last byte enters the output register.
// Reset clears frame position, checksum and both valid flags; registers take defaults.
// Output stalls hold the byte in place and back up into the sample input.
`timescale 1ns / 1ps
module sample_frame_builder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sfb_in_if.sink                      in_ch_i,
  sfb_out_if.source                   out_ch_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfb_pkg::APB_AW-1:0]  paddr,
  input  logic [sfb_pkg::APB_DW-1:0]  pwdata,
  output logic [sfb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import sfb_pkg::*;

  // byte positions within one sample's run
  localparam logic [2:0] STEP_PRE0   = 3'd0;
  localparam logic [2:0] STEP_PRE1   = 3'd1;
  localparam logic [2:0] STEP_START  = 3'd2;
  localparam logic [2:0] STEP_SAMPLE = 3'd3;
  localparam logic [2:0] STEP_CKSUM  = 3'd4;
  localparam logic [2:0] STEP_END    = 3'd5;

  cfg_t       cfg;
  item_t      item;
  logic       accept;

  logic       item_vld_q, item_vld_d;
  logic [2:0] step_q, step_d;
  item_t      held_q, held_d;

  logic       out_vld_q, out_vld_d;
  byte_t      out_byte_q, out_byte_d;
  kind_t      out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;

  logic       out_free;
  logic       emit;
  logic       at_last;
  byte_t      res_byte;
  kind_t      res_kind;

  sfb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfb_frame_ctl u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (in_ch_i.sample),
    .spf_i    (cfg.samples_per_frame),
    .item_o   (item)
  );

  assign out_free = !out_vld_q || out_ch_o.ready;
  assign emit     = item_vld_q && out_free;
  assign at_last  = held_q.last ? (step_q == STEP_END) : (step_q == STEP_SAMPLE);

  assign in_ch_i.ready = !item_vld_q || (emit && at_last);
  assign accept        = in_ch_i.valid && in_ch_i.ready;

  always_comb begin
    unique case (step_q)
      STEP_PRE0, STEP_PRE1: begin
        res_byte = cfg.preamble_byte;
        res_kind = KIND_PREAMBLE;
      end
      STEP_START: begin
        res_byte = cfg.start_byte;
        res_kind = KIND_START;
      end
      STEP_SAMPLE: begin
        res_byte = held_q.data;
        res_kind = KIND_SAMPLE;
      end
      STEP_CKSUM: begin
        res_byte = held_q.checksum;
        res_kind = KIND_CHECKSUM;
      end
      STEP_END: begin
        res_byte = cfg.end_byte;
        res_kind = KIND_END;
      end
      default: begin
        res_byte = held_q.data;
        res_kind = KIND_SAMPLE;
      end
    endcase
  end

  always_comb begin
    item_vld_d = item_vld_q;
    step_d     = step_q;
    held_d     = held_q;
    if (accept) begin
      item_vld_d = 1'b1;
      step_d     = item.first ? STEP_PRE0 : STEP_SAMPLE;
      held_d     = item;
    end else if (emit) begin
      if (at_last) begin
        item_vld_d = 1'b0;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_byte_d = res_byte;
      out_kind_d = res_kind;
      out_last_d = at_last;
    end else if (out_ch_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      step_q     <= STEP_PRE0;
      out_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      step_q     <= step_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_ch_o.valid       = out_vld_q;
  assign out_ch_o.tx_byte     = out_byte_q;
  assign out_ch_o.byte_kind   = out_kind_q;
  assign out_ch_o.last_of_run = out_last_q;

endmodule

>>> rtl/sfb_checker.sv
// Port-level checks on the frame byte stream, bound to the top level.
`timescale 1ns / 1ps
module sfb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [7:0]            tx_byte_i,
  input logic [2:0]            byte_kind_i,
  input logic                  last_of_run_i
);
  import sfb_pkg::*;

  kind_t prev_kind_q;
  logic  xfer;

  assign xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_kind_q <= KIND_END;
    end else if (xfer) begin
      prev_kind_q <= byte_kind_i;
    end
  end

  // a stalled byte stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_byte_i)
      && $stable(byte_kind_i) && $stable(last_of_run_i))
    else $error("output byte changed while stalled");

  a_start_after_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (byte_kind_i == KIND_START) |-> prev_kind_q == KIND_PREAMBLE)
    else $error("start flag not preceded by preamble");

  a_end_after_cksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (byte_kind_i == KIND_END) |-> prev_kind_q == KIND_CHECKSUM)
    else $error("end flag not preceded by checksum");

  // a run closes on the sample byte or on the end flag
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && last_of_run_i |-> (byte_kind_i == KIND_SAMPLE) || (byte_kind_i == KIND_END))
    else $error("run closed on a framing byte");

endmodule

bind sample_frame_builder sfb_checker u_sfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .tx_byte_i     (out_ch_o.tx_byte),
  .byte_kind_i   (out_ch_o.byte_kind),
  .last_of_run_i (out_ch_o.last_of_run)
);

>>> tb/tb_sample_frame_builder.sv
// Self-checking testbench for the sample frame builder: predicted frame bytes vs. DUT output.
`timescale 1ns / 1ps
module tb_sample_frame_builder;
  import sfb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    byte_t tx_byte;
    kind_t kind;
    logic  last;
  } frame_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sfb_in_if  in_ch ();
  sfb_out_if out_ch ();

  sample_frame_builder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state and shadow registers
  cfg_t        shadow_cfg;
  logic [7:0]  frame_pos;
  byte_t       frame_sum;
  frame_byte_t frame_bytes_q[$];

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned samples_sent;
  int unsigned n_frames;
  int unsigned n_bytes;
  int unsigned burst_left;
  int unsigned hold_left;

  function automatic void predict_frame_bytes(input sample_t s);
    frame_byte_t fb[6];
    int          n;
    int unsigned len;
    byte_t       b;
    n = 0;
    b = byte_t'(s >> (SAMPLE_BITS - BYTE_BITS));
    if (shadow_cfg.samples_per_frame == 0) len = 1;
    else if (shadow_cfg.samples_per_frame > 256) len = 256;
    else len = 32'(shadow_cfg.samples_per_frame);
    if (frame_pos == 0) begin
      fb[n] = '{shadow_cfg.preamble_byte, KIND_PREAMBLE, 1'b0};
      n = n + 1;
      fb[n] = '{shadow_cfg.preamble_byte, KIND_PREAMBLE, 1'b0};
      n = n + 1;
      fb[n] = '{shadow_cfg.start_byte, KIND_START, 1'b0};
      n = n + 1;
    end
    fb[n] = '{b, KIND_SAMPLE, 1'b0};
    n = n + 1;
    frame_sum = frame_sum + b;
    // a lowered length closes the frame as soon as the position reaches it
    if (int'(frame_pos) + 1 >= int'(len)) begin
      fb[n] = '{frame_sum, KIND_CHECKSUM, 1'b0};
      n = n + 1;
      fb[n] = '{shadow_cfg.end_byte, KIND_END, 1'b0};
      n = n + 1;
      frame_pos = '0;
      frame_sum = '0;
      n_frames++;
    end else begin
      frame_pos = frame_pos + 8'd1;
    end
    fb[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) frame_bytes_q.push_back(fb[i]);
  endfunction

  // output side: stall pattern, with a long hold-off on request
  initial begin : byte_sink
    int unsigned seg_left;
    int unsigned mode;
    seg_left = 0;
    mode     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 64);
        end
        seg_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : byte_check
    frame_byte_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (frame_bytes_q.size() == 0) begin
        $error("unexpected transfer: tx_byte %0h byte_kind %0d", out_ch.tx_byte,
               out_ch.byte_kind);
        errors++;
      end else begin
        want = frame_bytes_q.pop_front();
        n_bytes++;
        if (out_ch.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, out_ch.tx_byte);
          errors++;
        end
        if (out_ch.byte_kind !== want.kind) begin
          $error("byte_kind: expected %0d, got %0d", want.kind, out_ch.byte_kind);
          errors++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               frame_bytes_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== want) begin
      $error("prdata reg %0d: expected %0h, got %0h", idx, want, got);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] readback;
    apb_write(idx, data);
    readback = {24'd0, data[7:0]};
    case (idx)
      REG_SPF: begin
        shadow_cfg.samples_per_frame = data[SPF_BITS-1:0];
        readback = {23'd0, data[SPF_BITS-1:0]};
      end
      REG_PREAMBLE: shadow_cfg.preamble_byte = data[7:0];
      REG_START:    shadow_cfg.start_byte    = data[7:0];
      REG_END:      shadow_cfg.end_byte      = data[7:0];
      default: ;
    endcase
    check_reg(idx, readback);
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_frame_bytes(s);
    samples_sent++;
  endtask

  // stop offering and wait for every predicted byte, then let the pipe settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sample_t'($urandom_range(0, 3));
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic test_reset_values;
    check_reg(REG_SPF, {23'd0, SPF_RESET});
    check_reg(REG_PREAMBLE, {24'd0, PREAMBLE_RESET});
    check_reg(REG_START, {24'd0, START_RESET});
    check_reg(REG_END, {24'd0, END_RESET});
  endtask

  task automatic test_directed_frames;
    // one-sample frames, sample extremes
    write_reg(REG_SPF, 32'd1);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd3);
    send_sample(10'd4);
    send_sample(10'd512);
    drain();
    // zero length behaves as one
    write_reg(REG_SPF, 32'd0);
    send_sample(10'd1020);
    send_sample(10'd2);
    drain();
    // flag extremes, checksum wrap
    write_reg(REG_PREAMBLE, 32'h00);
    write_reg(REG_START, 32'hFF);
    write_reg(REG_END, 32'h00);
    write_reg(REG_SPF, 32'd4);
    repeat (4) send_sample(10'h3FF);
    drain();
    // length lowered below the current position mid-frame
    write_reg(REG_SPF, 32'd10);
    repeat (5) send_sample(pick_sample());
    drain();
    write_reg(REG_SPF, 32'd3);
    send_sample(10'd1);
    drain();
    write_reg(REG_PREAMBLE, 32'hFF);
    write_reg(REG_START, 32'h00);
    write_reg(REG_END, 32'hFF);
    write_reg(REG_SPF, 32'd2);
    send_sample(10'h155);
    send_sample(10'h2AA);
    drain();
  endtask

  // longest frame: above-range length first, then exactly 256
  task automatic test_long_frame;
    write_reg(REG_PREAMBLE, $urandom_range(0, 255));
    write_reg(REG_START, $urandom_range(0, 255));
    write_reg(REG_END, $urandom_range(0, 255));
    write_reg(REG_SPF, 32'd400);
    repeat (200) send_sample(pick_sample());
    drain();
    write_reg(REG_SPF, 32'd256);
    repeat (56) send_sample(pick_sample());
    drain();
  endtask

  task automatic test_backpressure;
    write_reg(REG_SPF, 32'd3);
    burst_left = 1000;
    hold_left  = 150;
    repeat (30) send_sample(pick_sample());
    burst_left = 0;
    drain();
  endtask

  task automatic test_random_frames;
    int unsigned spf;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 9))
        0: spf = 0;
        1: spf = 1;
        7, 8: spf = $urandom_range(9, 40);
        9: spf = $urandom_range(257, 511);
        default: spf = $urandom_range(2, 8);
      endcase
      write_reg(REG_SPF, spf);
      write_reg(REG_PREAMBLE, $urandom_range(0, 255));
      write_reg(REG_START, $urandom_range(0, 255));
      write_reg(REG_END, $urandom_range(0, 255));
      repeat (20) send_sample(pick_sample());
      drain();
    end
  endtask

  initial begin
    errors       = 0;
    cycle_count  = 0;
    samples_sent = 0;
    n_frames     = 0;
    n_bytes      = 0;
    burst_left   = 0;
    hold_left    = 0;
    frame_pos    = '0;
    frame_sum    = '0;
    shadow_cfg   = '{SPF_RESET, PREAMBLE_RESET, START_RESET, END_RESET};
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_frames();
    test_long_frame();
    test_backpressure();
    test_random_frames();

    drain();
    repeat (20) @(posedge clk_i);
    if (frame_bytes_q.size() != 0) begin
      $error("%0d predicted bytes never arrived", frame_bytes_q.size());
      errors++;
    end
    $display("Covered %0d samples in %0d closed frames, %0d bytes compared.",
             samples_sent, n_frames, n_bytes);
    $display("Frame lengths zero, 1..40, 256 and above range; lengths cut mid-frame.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
